// ===== rtl/llsm_pkg.sv =====
`default_nettype none

package llsm_pkg;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LINK_A,
        ST_LINK_B
    } llsm_state_t;

    // Result status codes
    typedef enum logic [1:0] {
        RES_OK,
        RES_ILLEGAL,
        RES_FULL
    } res_status_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch the transaction and read the slot memories
        logic link_a;      // first link update
        logic link_b;      // second link update and ok report
        logic report_err;  // report a rejected transaction
    } llsm_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        res_status_t check;
    } llsm_stat_t;

endpackage

`default_nettype wire

// ===== rtl/llsm_ctrl.sv =====
`default_nettype none

module llsm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire llsm_pkg::llsm_stat_t stat,
    output llsm_pkg::llsm_cmd_t     cmd
);
    import llsm_pkg::*;

    llsm_state_t state_reg;
    llsm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.check != RES_OK)
                begin
                    cmd.report_err = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LINK_A;
                end
            end
            ST_LINK_A:
            begin
                cmd.link_a = 1'b1;
                state_next = ST_LINK_B;
            end
            ST_LINK_B:
            begin
                cmd.link_b = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a check only ever follows an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> $past(start && !busy))
        else $error("check state entered without an accepted transaction");
`endif

endmodule

`default_nettype wire

// ===== rtl/llsm_datapath.sv =====
`default_nettype none

module llsm_datapath #(
    parameter int SLOTS       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire llsm_pkg::llsm_cmd_t  cmd,
    output llsm_pkg::llsm_stat_t      stat,
    input  wire logic                 kind,
    input  wire logic [9:0]           index,
    input  wire logic [31:0]          value,
    output logic                      done,
    output logic [1:0]                status,
    output logic [9:0]                slot,
    output logic [31:0]               removed_value,
    output logic [9:0]                head_slot,
    output logic [9:0]                tail_slot,
    output logic [9:0]                count
);
    import llsm_pkg::*;

    localparam int SW = $clog2(SLOTS);

    // slot memories; entry 0 of the link memories is unused (sentinel in registers)
    logic [SW-1:0]          next_mem [SLOTS];
    logic [SW-1:0]          prev_mem [SLOTS];
    logic                   live_mem [SLOTS];
    logic [VALUE_WIDTH-1:0] val_mem  [SLOTS];

    // control state
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [SW-1:0] free_head_reg, free_head_next;
    logic [SW-1:0] count_reg, count_next;
    logic [SW:0]   hwm_reg, hwm_next;
    logic          done_reg;

    // transaction payload
    logic                   kind_reg;
    logic [SW-1:0]          at_reg;
    logic [SW-1:0]          f_reg;
    logic [31:0]            val_reg;
    logic                   in_range_reg;
    logic [SW-1:0]          next_rd_a_reg;
    logic [SW-1:0]          next_rd_f_reg;
    logic [SW-1:0]          prev_rd_reg;
    logic                   live_rd_reg;
    logic [VALUE_WIDTH-1:0] val_rd_reg;
    res_status_t            status_reg;
    logic [SW-1:0]          slot_reg;
    logic [31:0]            removed_reg;

    // write ports
    logic                   next_we, prev_we, live_we, val_we;
    logic [SW-1:0]          next_waddr, prev_waddr, live_waddr, val_waddr;
    logic [SW-1:0]          next_wdata, prev_wdata;
    logic                   live_wdata;

    logic [SW-1:0] rd_addr;
    logic          at_touched;
    logic          at_live;
    logic          f_touched;
    logic [SW-1:0] nxt_at;
    logic [SW-1:0] prv_at;
    logic [SW-1:0] nxt_f;

    assign rd_addr    = SW'(index);
    assign at_touched = ({1'b0, at_reg} < hwm_reg);
    assign f_touched  = ({1'b0, f_reg} < hwm_reg);
    assign at_live    = (at_reg == '0) ? 1'b1 : (at_touched & live_rd_reg);
    assign nxt_at     = (at_reg == '0) ? head_reg : next_rd_a_reg;
    assign prv_at     = (at_reg == '0) ? tail_reg : prev_rd_reg;
    // untouched free slots chain upwards, the last one ends the chain
    assign nxt_f      = f_touched ? next_rd_f_reg :
                        ((f_reg == SW'(SLOTS - 1)) ? '0 : SW'(f_reg + 1'b1));

    always_comb
    begin
        if (!in_range_reg || !at_live || (kind_reg && at_reg == '0))
        begin
            stat.check = RES_ILLEGAL;
        end
        else if (!kind_reg && free_head_reg == '0)
        begin
            stat.check = RES_FULL;
        end
        else
        begin
            stat.check = RES_OK;
        end
    end

    always_comb
    begin
        next_we        = 1'b0;
        prev_we        = 1'b0;
        live_we        = 1'b0;
        val_we         = 1'b0;
        next_waddr     = at_reg;
        prev_waddr     = at_reg;
        live_waddr     = at_reg;
        val_waddr      = f_reg;
        next_wdata     = '0;
        prev_wdata     = '0;
        live_wdata     = 1'b0;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        hwm_next       = hwm_reg;
        if (cmd.link_a)
        begin
            if (!kind_reg)
            begin
                // fill the new slot and pop the free list
                next_we        = 1'b1;
                next_waddr     = f_reg;
                next_wdata     = nxt_at;
                prev_we        = 1'b1;
                prev_waddr     = f_reg;
                prev_wdata     = at_reg;
                live_we        = 1'b1;
                live_waddr     = f_reg;
                live_wdata     = 1'b1;
                val_we         = 1'b1;
                free_head_next = nxt_f;
                count_next     = count_reg + 1'b1;
                if (!f_touched)
                begin
                    hwm_next = hwm_reg + 1'b1;
                end
            end
            else
            begin
                // bridge the neighbours over the slot
                if (prv_at == '0)
                begin
                    head_next = nxt_at;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = prv_at;
                    next_wdata = nxt_at;
                end
                if (nxt_at == '0)
                begin
                    tail_next = prv_at;
                end
                else
                begin
                    prev_we    = 1'b1;
                    prev_waddr = nxt_at;
                    prev_wdata = prv_at;
                end
                live_we    = 1'b1;
                live_wdata = 1'b0;
            end
        end
        if (cmd.link_b)
        begin
            if (!kind_reg)
            begin
                if (at_reg == '0)
                begin
                    head_next = f_reg;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_wdata = f_reg;
                end
                if (nxt_at == '0)
                begin
                    tail_next = f_reg;
                end
                else
                begin
                    prev_we    = 1'b1;
                    prev_waddr = nxt_at;
                    prev_wdata = f_reg;
                end
            end
            else
            begin
                // push the slot onto the free list
                next_we        = 1'b1;
                next_wdata     = free_head_reg;
                prev_we        = 1'b1;
                prev_wdata     = '0;
                free_head_next = at_reg;
                count_next     = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.capture)
        begin
            next_rd_a_reg <= next_mem[rd_addr];
            next_rd_f_reg <= next_mem[free_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (cmd.capture)
        begin
            prev_rd_reg <= prev_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_waddr] <= live_wdata;
        end
        if (cmd.capture)
        begin
            live_rd_reg <= live_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= VALUE_WIDTH'(val_reg);
        end
        if (cmd.capture)
        begin
            val_rd_reg <= val_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            free_head_reg <= SW'(1);
            count_reg     <= '0;
            hwm_reg       <= (SW+1)'(1);
            done_reg      <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            hwm_reg       <= hwm_next;
            done_reg      <= cmd.report_err | cmd.link_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg     <= kind;
            at_reg       <= rd_addr;
            f_reg        <= free_head_reg;
            val_reg      <= value;
            in_range_reg <= (32'(index) < 32'(SLOTS));
        end
        if (cmd.report_err)
        begin
            status_reg  <= stat.check;
            slot_reg    <= '0;
            removed_reg <= '0;
        end
        else if (cmd.link_b)
        begin
            status_reg  <= RES_OK;
            slot_reg    <= kind_reg ? at_reg : f_reg;
            removed_reg <= kind_reg ? 32'(val_rd_reg) : '0;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign slot          = 10'(slot_reg);
    assign removed_value = removed_reg;
    assign head_slot     = 10'(head_reg);
    assign tail_slot     = 10'(tail_reg);
    assign count         = 10'(count_reg);

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (((count_reg == '0) == (head_reg == '0)) &&
                      ((count_reg == '0) == (tail_reg == '0))))
        else $error("sentinel links disagree with element count");

    assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg == '0) |-> (count_reg == SW'(SLOTS - 1)))
        else $error("free list empty while store not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} < hwm_reg) && (hwm_reg <= (SW+1)'(SLOTS)))
        else $error("high-water mark out of step with element count");
`endif

endmodule

`default_nettype wire

// ===== rtl/linked_list_slot_manager.sv =====
`default_nettype none

// Doubly linked list in slot memories, with slot 0 as the circular sentinel
// and a singly linked free list. Raise start with kind, index and value while
// busy is low; the transaction is taken on that edge. Exactly one result
// follows: done is high for a single cycle with status, slot, removed_value,
// head_slot, tail_slot and count, and the receiver cannot hold it off, so
// sample it then. A good insert or delete goes through the check state and
// two link-update states, and start may be high again in the done cycle, so
// a new transaction can be taken while the last result is shown. A rejected
// transaction (dead or out-of-range slot, delete of the sentinel, insert into
// a full store) goes from the check state to its result and changes nothing.
// The sequence is set by the link memories: each has a single write port and
// every operation rewrites two next links and two prev links, hence two updates.
// The sentinel links are held in registers, and no clearing pass is needed
// after reset: slots never yet allocated are recognised by a high-water mark,
// so the block can take a transaction on the first cycle out of reset.
module linked_list_slot_manager #(
    parameter int SLOTS       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        kind,
    input  wire logic [9:0]  index,
    input  wire logic [31:0] value,
    output logic             done,
    output logic [1:0]       status,
    output logic [9:0]       slot,
    output logic [31:0]      removed_value,
    output logic [9:0]       head_slot,
    output logic [9:0]       tail_slot,
    output logic [9:0]       count
);
    import llsm_pkg::*;

    llsm_cmd_t  cmd;
    llsm_stat_t stat;

    // sequence: accept, check, first link update, second link update
    llsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // slot memories, sentinel and free-list registers, result registers
    llsm_datapath #(
        .SLOTS       (SLOTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .kind          (kind),
        .index         (index),
        .value         (value),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .removed_value (removed_value),
        .head_slot     (head_slot),
        .tail_slot     (tail_slot),
        .count         (count)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import llsm_pkg::*;

    localparam int SLOTS      = 1024;
    localparam int QUIET_MAX  = 1000;  // cycles with no handshake before giving up
    localparam int DRAIN_WAIT = 16;    // settle time once every result is in

    // Transaction kinds as seen on the kind port
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // One result as the block should report it
    typedef struct packed {
        res_status_t status;
        logic [9:0]  slot;
        logic [31:0] removed;
        logic [9:0]  head;
        logic [9:0]  tail;
        logic [9:0]  count;
    } outcome_t;

    // One pending transaction, carrying the result worked out when it was planned
    typedef struct packed {
        logic     kind;
        logic [9:0]  index;
        logic [31:0] value;
        outcome_t    want;
    } list_op_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        kind  = 1'b0;
    logic [9:0]  index = '0;
    logic [31:0] value = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [9:0]  slot;
    logic [31:0] removed_value;
    logic [9:0]  head_slot;
    logic [9:0]  tail_slot;
    logic [9:0]  count;

    // Shadow copy of the slot store, advanced in stimulus order. Since every
    // transaction yields exactly one result and results come back in order,
    // planning order equals acceptance order.
    logic [31:0] val_mem  [SLOTS];
    logic [9:0]  fwd_link [SLOTS];
    logic [9:0]  back_link[SLOTS];
    logic        in_use   [SLOTS];
    logic [9:0]  free_top;
    logic [9:0]  n_live;
    logic [9:0]  live_slots[$];   // live slots other than the sentinel, for picking

    list_op_t op_q[$];        // transactions not yet offered to the block
    outcome_t outcome_q[$];   // results owed by transactions already accepted
    int       faults = 0;
    int       n_sent = 0;
    int       quiet_cycles = 0;

    linked_list_slot_manager i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .index         (index),
        .value         (value),
        .done          (done),
        .status        (status),
        .slot          (slot),
        .removed_value (removed_value),
        .head_slot     (head_slot),
        .tail_slot     (tail_slot),
        .count         (count)
    );

    always #1 clk = ~clk;

    // Apply one transaction to the shadow store and return the result it owes.
    // Rejected transactions leave the store untouched and report its state.
    function automatic outcome_t apply_list_op(logic op_kind, logic [9:0] at,
                                               logic [31:0] word);
        outcome_t   r;
        logic [9:0] f;
        logic [9:0] n;
        logic [9:0] p;
        r.status  = RES_OK;
        r.slot    = '0;
        r.removed = '0;
        if (!in_use[at] || (op_kind == OP_DELETE && at == 0))
        begin
            r.status = RES_ILLEGAL;
        end
        else if (op_kind == OP_INSERT && free_top == 0)
        begin
            r.status = RES_FULL;
        end
        else if (op_kind == OP_INSERT)
        begin
            // take the first free slot and splice it in after the anchor
            f            = free_top;
            free_top     = fwd_link[f];
            val_mem[f]   = word;
            n            = fwd_link[at];
            back_link[f] = at;
            fwd_link[f]  = n;
            back_link[n] = f;
            fwd_link[at] = f;
            in_use[f]    = 1'b1;
            n_live       = n_live + 1'b1;
            r.slot       = f;
        end
        else
        begin
            // unlink the slot and push it onto the free chain
            r.removed     = val_mem[at];
            p             = back_link[at];
            n             = fwd_link[at];
            fwd_link[p]   = n;
            back_link[n]  = p;
            back_link[at] = '0;
            fwd_link[at]  = free_top;
            free_top      = at;
            in_use[at]    = 1'b0;
            n_live        = n_live - 1'b1;
            r.slot        = at;
        end
        // the sentinel links are the head and tail
        r.head  = fwd_link[0];
        r.tail  = back_link[0];
        r.count = n_live;
        return r;
    endfunction

    // Queue a transaction together with its expected result, and keep the
    // list of live slots in step so that later picks stay well formed.
    task automatic plan_op(logic op_kind, logic [9:0] at, logic [31:0] word);
        list_op_t op;
        int       k;
        op.kind  = op_kind;
        op.index = at;
        op.value = word;
        op.want  = apply_list_op(op_kind, at, word);
        op_q.push_back(op);
        if (op.want.status == RES_OK)
        begin
            if (op_kind == OP_INSERT)
            begin
                live_slots.push_back(op.want.slot);
            end
            else
            begin
                for (k = 0; k < live_slots.size(); k++)
                begin
                    if (live_slots[k] == at)
                    begin
                        live_slots.delete(k);
                        break;
                    end
                end
            end
        end
    endtask

    // Data words lean towards the extremes now and then.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed traffic on live slots, with a little noise on any
    // slot at all. With until_full set, stop once every slot is in use.
    task automatic plan_mix(int n, int ins_pct, bit until_full);
        int         i;
        logic [9:0] anchor;
        for (i = 0; i < n; i++)
        begin
            if (until_full && n_live == SLOTS - 1)
            begin
                break;
            end
            if ($urandom_range(99) < 6)
            begin
                plan_op(1'($urandom_range(1)), 10'($urandom_range(SLOTS - 1)), pick_word());
            end
            else if (live_slots.size() == 0 || $urandom_range(99) < ins_pct)
            begin
                if (live_slots.size() == 0 || $urandom_range(99) < 15)
                begin
                    anchor = '0;
                end
                else
                begin
                    anchor = live_slots[$urandom_range(live_slots.size() - 1)];
                end
                plan_op(OP_INSERT, anchor, pick_word());
            end
            else
            begin
                plan_op(OP_DELETE, live_slots[$urandom_range(live_slots.size() - 1)],
                        pick_word());
            end
        end
    endtask

    // Record one failure; report only the first few in full.
    task automatic note_fault(string what, logic [31:0] want, logic [31:0] got);
        faults++;
        if (faults <= 10)
        begin
            $display("%0t: %s: expected %0h, got %0h", $realtime, what, want, got);
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            note_fault({name, " mismatch"}, want, got);
        end
    endtask

    // Driver: offer the next transaction from op_q, hold it until the block
    // takes it, and idle at random except through a stretch mid-run with no idling.
    always @(posedge clk or negedge rst_n)
    begin : drive_p
        list_op_t held_op;
        bit       taken;
        bit       skip;
        if (!rst_n)
        begin
            start <= 1'b0;
            kind  <= 1'b0;
            index <= '0;
            value <= '0;
        end
        else
        begin
            taken = start && (busy === 1'b0);
            if (taken)
            begin
                // the transaction went in on this edge, so its result is now owed
                outcome_q.push_back(held_op.want);
                n_sent++;
            end
            skip = (n_sent < 500 || n_sent >= 800) && ($urandom_range(99) < 24);
            if (start && !taken)
            begin
                // hold the offer until the block takes it
            end
            else if (op_q.size() != 0 && !skip)
            begin
                held_op = op_q.pop_front();
                start   <= 1'b1;
                kind    <= held_op.kind;
                index   <= held_op.index;
                value   <= held_op.value;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest one owed.
    always @(posedge clk)
    begin : watch_p
        outcome_t want;
        if (rst_n && done === 1'b1)
        begin
            if (outcome_q.size() == 0)
            begin
                note_fault("result with none owed, status", '0, 32'(status));
            end
            else
            begin
                want = outcome_q.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("slot", 32'(want.slot), 32'(slot));
                check_field("removed_value", want.removed, removed_value);
                check_field("head_slot", 32'(want.head), 32'(head_slot));
                check_field("tail_slot", 32'(want.tail), 32'(tail_slot));
                check_field("count", 32'(want.count), 32'(count));
            end
        end
    end

    // Watchdog: give up when no transaction and no result moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || done === 1'b1)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_MAX)
            begin
                $display("timeout: no handshake for %0d cycles", QUIET_MAX);
                $display("testbench failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin : run_p
        int i;
        // Reset state of the shadow store: free chain 1, 2, ... SLOTS-1,
        // only the sentinel live, empty list.
        for (i = 0; i < SLOTS; i++)
        begin
            val_mem[i]   = '0;
            back_link[i] = '0;
            in_use[i]    = 1'b0;
            fwd_link[i]  = (i == 0 || i == SLOTS - 1) ? 10'd0 : 10'(i + 1);
        end
        in_use[0] = 1'b1;
        free_top  = 10'd1;
        n_live    = '0;

        // Directed part: rejections on an empty list, the sentinel, the top
        // slot, an insert into the empty list and a delete of its only
        // element, then head, middle and tail edits and reuse of freed slots.
        plan_op(OP_DELETE, 10'd0, 32'h0);
        plan_op(OP_DELETE, 10'd1, 32'h0);
        plan_op(OP_INSERT, 10'd5, 32'h1234_5678);
        plan_op(OP_INSERT, 10'd1023, 32'hFFFF_FFFF);
        plan_op(OP_DELETE, 10'd1023, 32'h0);
        plan_op(OP_INSERT, 10'd0, 32'h0000_0000);
        plan_op(OP_DELETE, 10'd1, 32'hFFFF_FFFF);
        plan_op(OP_INSERT, 10'd0, 32'hFFFF_FFFF);
        plan_op(OP_INSERT, 10'd1, 32'hA5A5_A5A5);
        plan_op(OP_INSERT, 10'd0, 32'h5A5A_5A5A);
        plan_op(OP_INSERT, 10'd2, 32'h0000_0001);
        plan_op(OP_INSERT, 10'd3, 32'h8000_0000);
        plan_op(OP_DELETE, 10'd3, 32'h0);
        plan_op(OP_DELETE, 10'd4, 32'h0);
        plan_op(OP_DELETE, 10'd5, 32'h0);
        plan_op(OP_DELETE, 10'd5, 32'h0);
        plan_op(OP_INSERT, 10'd5, 32'h0);
        plan_op(OP_DELETE, 10'd0, 32'h0);
        plan_op(OP_INSERT, 10'd1, 32'h7FFF_FFFF);
        plan_op(OP_INSERT, 10'd512, 32'hDEAD_BEEF);

        // Random part: mixed traffic, then fill every slot, then push on a
        // full store, then drain a good part of it again.
        plan_mix(120, 55, 1'b0);
        plan_mix(4000, 94, 1'b1);
        plan_mix(30, 70, 1'b0);
        plan_mix(100, 20, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every transaction has gone in and every result is back.
        @(negedge clk);
        while (op_q.size() != 0 || start || outcome_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_WAIT) @(negedge clk);

        if (outcome_q.size() != 0)
        begin
            note_fault("results still owed", '0, 32'(outcome_q.size()));
        end
        if (faults == 0)
        begin
            $display("testbench passed");
        end
        else
        begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
